FILE: sv/text_console_command_receiver_assert.svh
// Assertion macros for the text console command receiver RTL.
`ifndef TEXT_CONSOLE_COMMAND_RECEIVER_ASSERT_SVH
`define TEXT_CONSOLE_COMMAND_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/tcr_pkg.sv
// Package: types, constants and cursor helpers of the text console command receiver.
package tcr_pkg;

   // Default sizing
   localparam int PATTERN_LENGTH_DEF = 19;
   localparam int QUEUE_DEPTH_DEF    = 2;

   // Configuration register indexes
   localparam int CSR_COUNT = 6;
   localparam logic [2:0] CSR_TOGGLE_ONE   = 3'd0;
   localparam logic [2:0] CSR_TOGGLE_TWO   = 3'd1;
   localparam logic [2:0] CSR_TOGGLE_THREE = 3'd2;
   localparam logic [2:0] CSR_TOGGLE_FOUR  = 3'd3;
   localparam logic [2:0] CSR_ENTER        = 3'd4;
   localparam logic [2:0] CSR_ERASE        = 3'd5;

   localparam logic [7:0] CSR_RESET [CSR_COUNT] = '{8'd49, 8'd50, 8'd51, 8'd52, 8'd13, 8'd8};

   // Screen geometry
   localparam logic [8:0] LEFT_X = 9'd10;
   localparam logic [8:0] TOP_Y  = 9'd10;
   localparam logic [8:0] CELL_W = 9'd16;
   localparam logic [8:0] LINE_H = 9'd25;
   localparam logic [8:0] MAX_X  = 9'd452;
   localparam logic [8:0] MAX_Y  = 9'd250;

   // Cell counts for cursor advances
   localparam logic [4:0] LABEL_CELLS = 5'h17;
   localparam logic [4:0] ON_CELLS    = 5'h2;
   localparam logic [4:0] OFF_CELLS   = 5'h3;
   localparam logic [4:0] CHAR_CELLS  = 5'h1;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // Start-of-transfer text
   localparam int TEXT_LEN = 19;
   localparam logic [7:0] START_TEXT [TEXT_LEN] = '{
      "F", "I", "L", "E", " ", "T", "R", "A", "N", "S",
      "F", "E", "R", " ", "S", "T", "A", "R", "T"};

   // Result action codes
   typedef enum logic [2:0] {
      ACT_REDRAW  = 3'd0,
      ACT_CHAR    = 3'd1,
      ACT_LABEL   = 3'd2,
      ACT_STATE   = 3'd3,
      ACT_PIN     = 3'd4,
      ACT_FORWARD = 3'd5
   } action_type;

   // Decoded command kinds passed from front to back
   typedef enum logic [2:0] {
      CMD_FORWARD,
      CMD_TOGGLE,
      CMD_ENTER,
      CMD_ERASE,
      CMD_CHAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;   // character, forwarded byte or pin number 1..4
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_TOG_LINE,
      BK_TOG_LABEL,
      BK_TOG_STATE,
      BK_CHAR_DRAW
   } back_state_type;

   typedef struct packed {
      logic [8:0] x;
      logic [8:0] y;
      logic       wrap;
   } cursor_type;

   // Expected byte at a window position; zero past the text
   function automatic logic [7:0] pattern_byte(input logic [4:0] idx);
      logic [7:0] val;
      val = 8'h00;
      if (idx < 5'(TEXT_LEN)) begin
         val = START_TEXT[idx];
      end
      return val;
   endfunction

   // Line feed: x back to left margin, y down one line, wrap to top
   function automatic cursor_type newline_fn(input logic [8:0] y);
      cursor_type c;
      logic [9:0] sy;
      sy     = {1'b0, y} + {1'b0, LINE_H};
      c.x    = LEFT_X;
      c.y    = sy[8:0];
      c.wrap = 1'b0;
      if (sy > {1'b0, MAX_Y}) begin
         c.y    = TOP_Y;
         c.wrap = 1'b1;
      end
      return c;
   endfunction

   // Advance by cells; wrap reports a screen wrap
   function automatic cursor_type advance_fn(input logic [8:0] x, input logic [8:0] y,
                                             input logic [4:0] cells);
      cursor_type c;
      logic [10:0] sx;
      sx     = {2'b00, x} + {2'b00, cells, 4'b0000};
      c      = newline_fn(y);
      if (sx <= {2'b00, MAX_X}) begin
         c.x    = sx[8:0];
         c.y    = y;
         c.wrap = 1'b0;
      end
      return c;
   endfunction

endpackage

FILE: sv/tcr_req_if.sv
// Input channel interface: received byte beats.
interface tcr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/tcr_rsp_if.sv
// Result channel interface: display, pin and forward beats.
interface tcr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [8:0] x_pos;
   logic [8:0] y_pos;
   logic [7:0] payload;
   logic       level;
   logic       last;

   modport source (output valid, output action, output x_pos, output y_pos,
                   output payload, output level, output last, input ready);
   modport sink   (input valid, input action, input x_pos, input y_pos,
                   input payload, input level, input last, output ready);
endinterface

FILE: sv/tcr_fifo.sv
// Short command queue between the front and back parts.
module tcr_fifo #(
   parameter int DEPTH = tcr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tcr_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output tcr_pkg::cmd_type out_cmd
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tcr_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end
endmodule

FILE: sv/tcr_front.sv
// Front part: byte intake, start-text window, mode tracking and command decode.
module tcr_front #(
   parameter int PATTERN_LENGTH = tcr_pkg::PATTERN_LENGTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   tcr_req_if.sink          req_chan,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output tcr_pkg::cmd_type cmd_out
);
   logic [7:0] cfg_ff [tcr_pkg::CSR_COUNT];
   logic [7:0] win_ff [PATTERN_LENGTH];
   logic [7:0] win_in [PATTERN_LENGTH];
   logic       pass_ff, pass_in;
   logic       accept;
   logic       match;
   logic [7:0] rx;

   assign rx             = req_chan.rx_byte;
   assign req_chan.ready = cmd_ready;
   assign cmd_valid      = req_chan.valid;
   assign accept         = req_chan.valid && cmd_ready;

   // configuration writes; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tcr_pkg::CSR_COUNT; i++) begin
            cfg_ff[i] <= tcr_pkg::CSR_RESET[i];
         end
      end else if (csr_we && (csr_index < 3'(tcr_pkg::CSR_COUNT))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // shifted window and compare against the start text
   always_comb begin
      for (int i = 0; i < PATTERN_LENGTH - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[PATTERN_LENGTH - 1] = rx;
      match = 1'b1;
      for (int i = 0; i < PATTERN_LENGTH; i++) begin
         if (win_in[i] != tcr_pkg::pattern_byte(5'(i))) begin
            match = 1'b0;
         end
      end
      pass_in = pass_ff || match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b0;
         for (int i = 0; i < PATTERN_LENGTH; i++) begin
            win_ff[i] <= 8'h00;
         end
      end else if (accept && !pass_ff) begin
         pass_ff <= pass_in;
         for (int i = 0; i < PATTERN_LENGTH; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // decode; first matching register wins
   always_comb begin
      cmd_out.data = rx;
      if (pass_ff) begin
         cmd_out.kind = tcr_pkg::CMD_FORWARD;
      end else if (rx == cfg_ff[tcr_pkg::CSR_TOGGLE_ONE]) begin
         cmd_out.kind = tcr_pkg::CMD_TOGGLE;
         cmd_out.data = 8'd1;
      end else if (rx == cfg_ff[tcr_pkg::CSR_TOGGLE_TWO]) begin
         cmd_out.kind = tcr_pkg::CMD_TOGGLE;
         cmd_out.data = 8'd2;
      end else if (rx == cfg_ff[tcr_pkg::CSR_TOGGLE_THREE]) begin
         cmd_out.kind = tcr_pkg::CMD_TOGGLE;
         cmd_out.data = 8'd3;
      end else if (rx == cfg_ff[tcr_pkg::CSR_TOGGLE_FOUR]) begin
         cmd_out.kind = tcr_pkg::CMD_TOGGLE;
         cmd_out.data = 8'd4;
      end else if (rx == cfg_ff[tcr_pkg::CSR_ENTER]) begin
         cmd_out.kind = tcr_pkg::CMD_ENTER;
      end else if (rx == cfg_ff[tcr_pkg::CSR_ERASE]) begin
         cmd_out.kind = tcr_pkg::CMD_ERASE;
      end else begin
         cmd_out.kind = tcr_pkg::CMD_CHAR;
      end
   end
endmodule

FILE: sv/tcr_back.sv
// Back part: cursor, pin state and result sequencing with an output register.
module tcr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  tcr_pkg::cmd_type cmd_in,
   tcr_rsp_if.source        rsp_chan
);
   `include "text_console_command_receiver_assert.svh"

   tcr_pkg::back_state_type state_ff, state_in;
   logic [8:0] x_ff, x_in;
   logic [8:0] y_ff, y_in;
   logic       clr_ff, clr_in;
   logic       nl_ff, nl_in;
   logic [3:0] pins_ff, pins_in;
   logic [7:0] data_ff, data_in;
   logic       lvl_ff, lvl_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_action_ff, out_action_in;
   logic [8:0] out_x_ff, out_x_in;
   logic [8:0] out_y_ff, out_y_in;
   logic [7:0] out_payload_ff, out_payload_in;
   logic       out_level_ff, out_level_in;
   logic       out_last_ff, out_last_in;

   // one emission per step
   logic       e_valid;
   tcr_pkg::action_type e_action;
   logic [8:0] e_x, e_y;
   logic [7:0] e_payload;
   logic       e_level, e_last;

   logic slot_free, step;

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign cmd_ready = (state_ff == tcr_pkg::BK_IDLE) && slot_free;
   assign step      = slot_free && ((state_ff != tcr_pkg::BK_IDLE) || cmd_valid);

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.action  = out_action_ff;
   assign rsp_chan.x_pos   = out_x_ff;
   assign rsp_chan.y_pos   = out_y_ff;
   assign rsp_chan.payload = out_payload_ff;
   assign rsp_chan.level   = out_level_ff;
   assign rsp_chan.last    = out_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      if (step) begin
         unique case (state_ff)
            tcr_pkg::BK_IDLE: begin
               unique case (cmd_in.kind)
                  tcr_pkg::CMD_TOGGLE: state_in = tcr_pkg::BK_TOG_LINE;
                  tcr_pkg::CMD_CHAR:   state_in = tcr_pkg::BK_CHAR_DRAW;
                  default:             state_in = tcr_pkg::BK_IDLE;
               endcase
            end
            tcr_pkg::BK_TOG_LINE:  state_in = tcr_pkg::BK_TOG_LABEL;
            tcr_pkg::BK_TOG_LABEL: state_in = tcr_pkg::BK_TOG_STATE;
            default:               state_in = tcr_pkg::BK_IDLE;
         endcase
      end
   end

   // step actions and emissions
   always_comb begin
      tcr_pkg::cursor_type nl_c;
      tcr_pkg::cursor_type adv_c;
      logic [1:0] sel;
      logic       lvl;

      x_in      = x_ff;
      y_in      = y_ff;
      clr_in    = clr_ff;
      nl_in     = nl_ff;
      pins_in   = pins_ff;
      data_in   = data_ff;
      lvl_in    = lvl_ff;
      e_valid   = 1'b0;
      e_action  = tcr_pkg::ACT_REDRAW;
      e_x       = 9'd0;
      e_y       = 9'd0;
      e_payload = 8'd0;
      e_level   = 1'b0;
      e_last    = 1'b0;

      nl_c  = tcr_pkg::newline_fn(y_ff);
      adv_c = tcr_pkg::advance_fn(x_ff, y_ff, tcr_pkg::CHAR_CELLS);
      sel   = cmd_in.data[1:0] - 2'd1;
      lvl   = ~pins_ff[sel];

      if (step) begin
         unique case (state_ff)
            tcr_pkg::BK_IDLE: begin
               data_in = cmd_in.data;
               case (cmd_in.kind)
                  tcr_pkg::CMD_FORWARD: begin
                     e_valid   = 1'b1;
                     e_action  = tcr_pkg::ACT_FORWARD;
                     e_payload = cmd_in.data;
                     e_last    = 1'b1;
                  end
                  tcr_pkg::CMD_TOGGLE: begin
                     pins_in[sel] = lvl;
                     lvl_in       = lvl;
                     e_valid      = 1'b1;
                     e_action     = tcr_pkg::ACT_PIN;
                     e_payload    = cmd_in.data;
                     e_level      = lvl;
                  end
                  tcr_pkg::CMD_ENTER: begin
                     x_in    = nl_c.x;
                     y_in    = nl_c.y;
                     e_valid = nl_c.wrap;
                     e_last  = 1'b1;
                  end
                  tcr_pkg::CMD_ERASE: begin
                     if (x_ff == tcr_pkg::LEFT_X || x_ff < tcr_pkg::CELL_W) begin
                        // line start: back to end of previous line unless at top
                        if (y_ff != tcr_pkg::TOP_Y) begin
                           y_in      = y_ff - tcr_pkg::LINE_H;
                           x_in      = tcr_pkg::MAX_X;
                           e_valid   = 1'b1;
                           e_action  = tcr_pkg::ACT_CHAR;
                           e_x       = tcr_pkg::MAX_X;
                           e_y       = y_ff - tcr_pkg::LINE_H;
                           e_payload = tcr_pkg::SPACE_CHAR;
                           e_last    = 1'b1;
                        end
                     end else begin
                        x_in      = x_ff - tcr_pkg::CELL_W;
                        e_valid   = 1'b1;
                        e_action  = tcr_pkg::ACT_CHAR;
                        e_x       = x_ff - tcr_pkg::CELL_W;
                        e_y       = y_ff;
                        e_payload = tcr_pkg::SPACE_CHAR;
                        e_last    = 1'b1;
                     end
                  end
                  tcr_pkg::CMD_CHAR: begin
                     // pending clear wins over pending newline
                     if (clr_ff) begin
                        clr_in  = 1'b0;
                        e_valid = 1'b1;
                     end else if (nl_ff) begin
                        nl_in   = 1'b0;
                        x_in    = nl_c.x;
                        y_in    = nl_c.y;
                        e_valid = nl_c.wrap;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            tcr_pkg::BK_TOG_LINE: begin
               if (x_ff != tcr_pkg::LEFT_X) begin
                  x_in    = nl_c.x;
                  y_in    = nl_c.y;
                  e_valid = nl_c.wrap;
               end
            end
            tcr_pkg::BK_TOG_LABEL: begin
               adv_c     = tcr_pkg::advance_fn(x_ff, y_ff, tcr_pkg::LABEL_CELLS);
               x_in      = adv_c.x;
               y_in      = adv_c.y;
               clr_in    = clr_ff || adv_c.wrap;
               e_valid   = 1'b1;
               e_action  = tcr_pkg::ACT_LABEL;
               e_x       = x_ff;
               e_y       = y_ff;
               e_payload = data_ff;
            end
            tcr_pkg::BK_TOG_STATE: begin
               adv_c     = tcr_pkg::advance_fn(x_ff, y_ff,
                              lvl_ff ? tcr_pkg::ON_CELLS : tcr_pkg::OFF_CELLS);
               x_in      = adv_c.x;
               y_in      = adv_c.y;
               clr_in    = clr_ff || adv_c.wrap;
               nl_in     = 1'b1;
               e_valid   = 1'b1;
               e_action  = tcr_pkg::ACT_STATE;
               e_x       = x_ff;
               e_y       = y_ff;
               e_payload = data_ff;
               e_level   = lvl_ff;
               e_last    = 1'b1;
            end
            tcr_pkg::BK_CHAR_DRAW: begin
               x_in      = adv_c.x;
               y_in      = adv_c.y;
               clr_in    = clr_ff || adv_c.wrap;
               e_valid   = 1'b1;
               e_action  = tcr_pkg::ACT_CHAR;
               e_x       = x_ff;
               e_y       = y_ff;
               e_payload = data_ff;
               e_last    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // output register load
   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_action_in  = out_action_ff;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_payload_in = out_payload_ff;
      out_level_in   = out_level_ff;
      out_last_in    = out_last_ff;
      if (e_valid) begin
         out_valid_in   = 1'b1;
         out_action_in  = e_action;
         out_x_in       = e_x;
         out_y_in       = e_y;
         out_payload_in = e_payload;
         out_level_in   = e_level;
         out_last_in    = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcr_pkg::BK_IDLE;
         x_ff         <= tcr_pkg::LEFT_X;
         y_ff         <= tcr_pkg::TOP_Y;
         clr_ff       <= 1'b0;
         nl_ff        <= 1'b0;
         pins_ff      <= 4'h0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         clr_ff       <= clr_in;
         nl_ff        <= nl_in;
         pins_ff      <= pins_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff        <= data_in;
      lvl_ff         <= lvl_in;
      out_action_ff  <= out_action_in;
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_payload_ff <= out_payload_in;
      out_level_ff   <= out_level_in;
      out_last_ff    <= out_last_in;
   end

   // cursor stays on screen; a closing beat always returns the sequencer to idle
   `TCR_ASSERT_IMP(a_x_on_screen, clock, reset, 1'b1, x_ff <= tcr_pkg::MAX_X, "cursor x off screen")
   `TCR_ASSERT_IMP(a_y_on_screen, clock, reset, 1'b1, (y_ff >= tcr_pkg::TOP_Y) && (y_ff <= tcr_pkg::MAX_Y), "cursor y off screen")
   `TCR_ASSERT_NXT(a_last_to_idle, clock, reset, e_valid && e_last, state_ff == tcr_pkg::BK_IDLE, "last beat not at end of command")
endmodule

FILE: sv/text_console_command_receiver.sv
// Top level of the text console command receiver.
//
//   channel    dir   handshake          payload
//   req_chan   in    valid/ready        rx_byte
//   rsp_chan   out   valid/ready        action, x_pos, y_pos, payload, level, last
//   csr_*      in    csr_we             csr_index, csr_wdata
//
// The front takes one byte per cycle while the command queue has room.
// The back sequencer runs forward, enter and erase bytes in idle, characters in
// idle, draw; toggles in idle, line, label, state; one beat per cycle at most.
// A stalled result holds the output register and freezes the back; the queue
// then fills and holds off new bytes.
// Reset is synchronous and restores cursor, mode, pins and the default codes.
module text_console_command_receiver #(
   parameter int PATTERN_LENGTH = tcr_pkg::PATTERN_LENGTH_DEF,
   parameter int QUEUE_DEPTH    = tcr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tcr_req_if.sink    req_chan,
   tcr_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   logic             push_valid, push_ready;
   tcr_pkg::cmd_type push_cmd;
   logic             pop_valid, pop_ready;
   tcr_pkg::cmd_type pop_cmd;

   tcr_front #(
      .PATTERN_LENGTH (PATTERN_LENGTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd_out   (push_cmd)
   );

   tcr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_cmd   (pop_cmd)
   );

   tcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_in    (pop_cmd),
      .rsp_chan  (rsp_chan)
   );
endmodule

FILE: dv/tb_top.sv
// Testbench top: drives received bytes, predicts console commands and checks every result beat.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES  = 400;

   // One result beat as the block presents it
   typedef struct packed {
      tcr_pkg::action_type action;
      logic [8:0]          x_pos;
      logic [8:0]          y_pos;
      logic [7:0]          payload;
      logic                level;
      logic                last;
   } console_cmd_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   tcr_req_if req_bus ();
   tcr_rsp_if rsp_bus ();

   text_console_command_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Pending received bytes and console commands still to come
   logic [7:0]      rx_backlog [$];
   console_cmd_type awaited_cmds [$];
   console_cmd_type step_cmds [$];

   int idle_pct      = 0;
   int stall_pct     = 0;
   int bytes_taken   = 0;
   int bytes_sent    = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int mismatch_count = 0;

   // Shadow of the console state
   logic [7:0] code_reg [tcr_pkg::CSR_COUNT] = tcr_pkg::CSR_RESET;
   logic [7:0] rx_window [tcr_pkg::PATTERN_LENGTH_DEF] = '{default: 8'h00};
   logic       passthru    = 1'b0;
   logic [8:0] cur_x       = tcr_pkg::LEFT_X;
   logic [8:0] cur_y       = tcr_pkg::TOP_Y;
   logic       clear_due   = 1'b0;
   logic       newline_due = 1'b0;
   logic [3:0] pin_state   = 4'h0;

   function automatic void emit_cmd(input tcr_pkg::action_type act, input logic [8:0] x,
                                    input logic [8:0] y, input logic [7:0] data,
                                    input logic lvl);
      console_cmd_type c;
      c = '{act, x, y, data, lvl, 1'b0};
      step_cmds.push_back(c);
   endfunction

   // Carriage return plus line feed; a bottom wrap redraws the frame
   function automatic void line_feed();
      logic [9:0] ny;
      ny    = {1'b0, cur_y} + {1'b0, tcr_pkg::LINE_H};
      cur_x = tcr_pkg::LEFT_X;
      if (ny > {1'b0, tcr_pkg::MAX_Y}) begin
         cur_y = tcr_pkg::TOP_Y;
         emit_cmd(tcr_pkg::ACT_REDRAW, '0, '0, '0, 1'b0);
      end else begin
         cur_y = ny[8:0];
      end
   endfunction

   // Move right by whole cells; a bottom wrap only defers the clear
   function automatic void move_right(input logic [4:0] cells);
      logic [10:0] nx;
      logic [9:0]  ny;
      nx = {2'b00, cur_x} + {2'b00, cells, 4'b0000};
      if (nx > {2'b00, tcr_pkg::MAX_X}) begin
         ny    = {1'b0, cur_y} + {1'b0, tcr_pkg::LINE_H};
         cur_x = tcr_pkg::LEFT_X;
         if (ny > {1'b0, tcr_pkg::MAX_Y}) begin
            cur_y     = tcr_pkg::TOP_Y;
            clear_due = 1'b1;
         end else begin
            cur_y = ny[8:0];
         end
      end else begin
         cur_x = nx[8:0];
      end
   endfunction

   function automatic void toggle_pin(input logic [2:0] pin);
      logic [1:0] bitn;
      logic       lvl;
      bitn            = 2'(pin - 3'd1);
      pin_state[bitn] = ~pin_state[bitn];
      lvl             = pin_state[bitn];
      emit_cmd(tcr_pkg::ACT_PIN, '0, '0, {5'd0, pin}, lvl);
      if (cur_x != tcr_pkg::LEFT_X) line_feed();
      emit_cmd(tcr_pkg::ACT_LABEL, cur_x, cur_y, {5'd0, pin}, 1'b0);
      move_right(tcr_pkg::LABEL_CELLS);
      emit_cmd(tcr_pkg::ACT_STATE, cur_x, cur_y, {5'd0, pin}, lvl);
      move_right(lvl ? tcr_pkg::ON_CELLS : tcr_pkg::OFF_CELLS);
      newline_due = 1'b1;
   endfunction

   // Backspace: wraps to the end of the previous line, stuck at top-left
   function automatic void erase_cell();
      if (cur_x == tcr_pkg::LEFT_X || cur_x < tcr_pkg::CELL_W) begin
         if (cur_y != tcr_pkg::TOP_Y) begin
            cur_y = cur_y - tcr_pkg::LINE_H;
            cur_x = tcr_pkg::MAX_X;
            emit_cmd(tcr_pkg::ACT_CHAR, cur_x, cur_y, tcr_pkg::SPACE_CHAR, 1'b0);
         end
      end else begin
         cur_x = cur_x - tcr_pkg::CELL_W;
         emit_cmd(tcr_pkg::ACT_CHAR, cur_x, cur_y, tcr_pkg::SPACE_CHAR, 1'b0);
      end
   endfunction

   // Works out the command beats caused by one accepted byte
   function automatic void decode_rx_byte(input logic [7:0] b);
      logic       hit;
      logic [7:0] want;
      step_cmds.delete();
      if (passthru) begin
         emit_cmd(tcr_pkg::ACT_FORWARD, '0, '0, b, 1'b0);
      end else begin
         hit = 1'b1;
         for (int i = 0; i + 1 < tcr_pkg::PATTERN_LENGTH_DEF; i++) begin
            rx_window[i] = rx_window[i + 1];
         end
         rx_window[tcr_pkg::PATTERN_LENGTH_DEF - 1] = b;
         for (int i = 0; i < tcr_pkg::PATTERN_LENGTH_DEF; i++) begin
            want = (i < tcr_pkg::TEXT_LEN) ? tcr_pkg::START_TEXT[i] : 8'h00;
            if (rx_window[i] != want) hit = 1'b0;
         end
         // the byte that completes the text is still a keyboard byte
         if (hit) passthru = 1'b1;

         if (b == code_reg[tcr_pkg::CSR_TOGGLE_ONE]) toggle_pin(3'd1);
         else if (b == code_reg[tcr_pkg::CSR_TOGGLE_TWO]) toggle_pin(3'd2);
         else if (b == code_reg[tcr_pkg::CSR_TOGGLE_THREE]) toggle_pin(3'd3);
         else if (b == code_reg[tcr_pkg::CSR_TOGGLE_FOUR]) toggle_pin(3'd4);
         else if (b == code_reg[tcr_pkg::CSR_ENTER]) line_feed();
         else if (b == code_reg[tcr_pkg::CSR_ERASE]) erase_cell();
         else begin
            if (clear_due) begin
               emit_cmd(tcr_pkg::ACT_REDRAW, '0, '0, '0, 1'b0);
               clear_due = 1'b0;
            end else if (newline_due) begin
               line_feed();
               newline_due = 1'b0;
            end
            emit_cmd(tcr_pkg::ACT_CHAR, cur_x, cur_y, b, 1'b0);
            move_right(tcr_pkg::CHAR_CELLS);
         end
      end
      if (step_cmds.size() != 0) step_cmds[$].last = 1'b1;
      foreach (step_cmds[i]) awaited_cmds.push_back(step_cmds[i]);
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Byte driver: holds a beat until taken, random gaps between beats
   always @(negedge clock) begin : rx_driver
      logic taken_now;
      taken_now = 1'b0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         // the monitor counts beats taken at the last rising edge
         if (bytes_sent != bytes_taken) begin
            void'(rx_backlog.pop_front());
            bytes_sent++;
            taken_now = 1'b1;
         end
         if (req_bus.valid && !taken_now) begin
            // beat still on offer
         end else if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_bus.valid   <= 1'b1;
            req_bus.rx_byte <= rx_backlog[0];
         end else begin
            req_bus.valid   <= 1'b0;
            req_bus.rx_byte <= 8'($urandom);
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin : hold_timer
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_asked;
      end
   end

   // Receiver pacing
   always @(negedge clock) begin : rsp_pacer
      rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
   end

   // Prediction on accepted bytes, checking on accepted result beats
   always @(posedge clock) begin : console_monitor
      console_cmd_type seen;
      console_cmd_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         decode_rx_byte(req_bus.rx_byte);
         bytes_taken++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{tcr_pkg::action_type'(rsp_bus.action), rsp_bus.x_pos, rsp_bus.y_pos,
                  rsp_bus.payload, rsp_bus.level, rsp_bus.last};
         if (awaited_cmds.size() == 0) begin
            if (mismatch_count < 10)
               $display("%t: unexpected beat act=%0d x=%0d y=%0d data=%0h lvl=%0b last=%0b",
                        $realtime, seen.action, seen.x_pos, seen.y_pos, seen.payload,
                        seen.level, seen.last);
            mismatch_count++;
         end else begin
            want = awaited_cmds.pop_front();
            if (seen !== want) begin
               if (mismatch_count < 10) begin
                  $display("%t: beat mismatch", $realtime);
                  $display("   exp act=%0d x=%0d y=%0d data=%0h lvl=%0b last=%0b",
                           want.action, want.x_pos, want.y_pos, want.payload,
                           want.level, want.last);
                  $display("   got act=%0d x=%0d y=%0d data=%0h lvl=%0b last=%0b",
                           seen.action, seen.x_pos, seen.y_pos, seen.payload,
                           seen.level, seen.last);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Register write; only issued while the block is idle
   task automatic write_code(input logic [2:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      code_reg[idx] = val;
   endtask

   task automatic load_codes(input logic [7:0] t1, input logic [7:0] t2, input logic [7:0] t3,
                             input logic [7:0] t4, input logic [7:0] ent,
                             input logic [7:0] ers);
      write_code(tcr_pkg::CSR_TOGGLE_ONE, t1);
      write_code(tcr_pkg::CSR_TOGGLE_TWO, t2);
      write_code(tcr_pkg::CSR_TOGGLE_THREE, t3);
      write_code(tcr_pkg::CSR_TOGGLE_FOUR, t4);
      write_code(tcr_pkg::CSR_ENTER, ent);
      write_code(tcr_pkg::CSR_ERASE, ers);
   endtask

   task automatic set_idling(input int sender, input int receiver);
      @(posedge clock);
      idle_pct  = sender;
      stall_pct = receiver;
   endtask

   // Wait until every byte is taken and every beat seen, then let the block go quiet
   task automatic settle();
      while (rx_backlog.size() != 0 || awaited_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Keyboard traffic: character runs, commands, broken start texts, noise
   task automatic queue_keyboard_traffic(input int count);
      int         left;
      int         pick;
      int         run;
      int         cut;
      logic [7:0] b;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // long runs can fill a whole line and wrap the screen
            run = (pick < 30) ? $urandom_range(1, 8) : $urandom_range(26, 32);
            repeat (run) begin
               do begin
                  b = 8'($urandom);
               end while (b == code_reg[tcr_pkg::CSR_TOGGLE_ONE] ||
                          b == code_reg[tcr_pkg::CSR_TOGGLE_TWO] ||
                          b == code_reg[tcr_pkg::CSR_TOGGLE_THREE] ||
                          b == code_reg[tcr_pkg::CSR_TOGGLE_FOUR] ||
                          b == code_reg[tcr_pkg::CSR_ENTER] ||
                          b == code_reg[tcr_pkg::CSR_ERASE]);
               rx_backlog.push_back(b);
            end
            left -= run;
         end else if (pick < 55) begin
            rx_backlog.push_back(
               code_reg[tcr_pkg::CSR_TOGGLE_ONE + 3'($urandom_range(0, 3))]);
            left--;
         end else if (pick < 65) begin
            rx_backlog.push_back(code_reg[tcr_pkg::CSR_ENTER]);
            left--;
         end else if (pick < 77) begin
            run = $urandom_range(1, 5);
            repeat (run) rx_backlog.push_back(code_reg[tcr_pkg::CSR_ERASE]);
            left -= run;
         end else if (pick < 85) begin
            // start text cut short by a wrong byte
            cut = $urandom_range(1, tcr_pkg::TEXT_LEN - 1);
            for (int i = 0; i < cut; i++) rx_backlog.push_back(tcr_pkg::START_TEXT[i]);
            do begin
               b = 8'($urandom);
            end while (b == tcr_pkg::START_TEXT[cut]);
            rx_backlog.push_back(b);
            left -= cut + 1;
         end else begin
            rx_backlog.push_back(8'($urandom));
            left--;
         end
      end
   endtask

   // Stimulus and phase control
   initial begin : stimulus
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = tcr_pkg::CSR_TOGGLE_ONE;
      csr_wdata       = 8'h00;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part on reset codes: erase at top-left and at line start,
      // byte extremes, both pin levels, pending newline, frame redraw on enter
      rx_backlog = '{code_reg[tcr_pkg::CSR_ERASE], code_reg[tcr_pkg::CSR_ENTER],
                     code_reg[tcr_pkg::CSR_ERASE], 8'h00, 8'hFF,
                     code_reg[tcr_pkg::CSR_ERASE], code_reg[tcr_pkg::CSR_TOGGLE_ONE], "A",
                     code_reg[tcr_pkg::CSR_TOGGLE_ONE], code_reg[tcr_pkg::CSR_TOGGLE_TWO],
                     code_reg[tcr_pkg::CSR_TOGGLE_THREE], code_reg[tcr_pkg::CSR_TOGGLE_FOUR],
                     "Z", code_reg[tcr_pkg::CSR_ENTER], code_reg[tcr_pkg::CSR_ENTER],
                     code_reg[tcr_pkg::CSR_ENTER], code_reg[tcr_pkg::CSR_ENTER],
                     8'h7F, 8'h80, code_reg[tcr_pkg::CSR_ERASE]};
      queue_keyboard_traffic(30);
      settle();

      // Extreme codes, sender gaps
      load_codes(8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127);
      set_idling(71, 0);
      queue_keyboard_traffic(30);
      settle();

      // Duplicate codes, first in register order wins; receiver stalls
      load_codes(8'd65, 8'd65, 8'd66, 8'd67, 8'd66, 8'd68);
      set_idling(0, 71);
      queue_keyboard_traffic(30);
      settle();

      // Random codes, both sides idle
      load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
      set_idling(38, 38);
      queue_keyboard_traffic(30);
      settle();

      // Back pressure: receiver holds off while bytes keep coming
      set_idling(0, 0);
      @(negedge clock);
      hold_asked++;
      queue_keyboard_traffic(20);
      settle();

      // Start text switches to pass-through; everything after is forwarded
      load_codes(8'd49, 8'd50, 8'd51, 8'd52, 8'd13, 8'd8);
      set_idling(38, 38);
      queue_keyboard_traffic(8);
      for (int i = 0; i < tcr_pkg::TEXT_LEN; i++) rx_backlog.push_back(tcr_pkg::START_TEXT[i]);
      repeat (25) rx_backlog.push_back(8'($urandom));
      settle();

      if (mismatch_count == 0) begin
         $display("text_console_command_receiver verification clean");
      end else begin
         $display("text_console_command_receiver verification failed");
      end
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #400000;
      $display("text_console_command_receiver verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/tcr_pkg.sv
sv/tcr_req_if.sv
sv/tcr_rsp_if.sv
sv/tcr_fifo.sv
sv/tcr_front.sv
sv/tcr_back.sv
sv/text_console_command_receiver.sv
dv/tb_top.sv
